// ----- src/hashed_object_pairing_table_core_defines.svh -----
// assertion macros for the pairing table checker
`ifndef HASHED_OBJECT_PAIRING_TABLE_CORE_DEFINES_SVH
`define HASHED_OBJECT_PAIRING_TABLE_CORE_DEFINES_SVH

// implication checked at every clock edge outside reset
`define HOPT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define HOPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/hopt_pkg.sv -----
// ----------------------------------------------------------------------------
// hopt_pkg
// shared constants and types of the hashed object pairing table
// ----------------------------------------------------------------------------
`default_nettype none
package hopt_pkg;
    localparam int Capacity = 64;
    localparam int IdxW = $clog2(Capacity);
    localparam int CntW = $clog2(Capacity + 1);
    localparam int QDepth = 2;

    localparam logic [1:0] RegMaxEntries = 2'd0;
    localparam logic [1:0] RegHashBase = 2'd1;
    localparam logic [1:0] RegHashModulus = 2'd2;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [7:0]  cls;
        logic [31:0] stamp;
    } obj_t;

    // classified item: object and its key
    typedef struct packed {
        logic [15:0] key;
        obj_t        obj;
    } item_t;

    typedef struct packed {
        logic [15:0] key;
        obj_t        obj;
    } result_t;
endpackage
`default_nettype wire

// ----- src/hashed_object_pairing_table_core.sv -----
// ----------------------------------------------------------------------------
// hashed_object_pairing_table_core
// pairs sensor objects by hash key in a 64-slot table with oldest eviction
// ----------------------------------------------------------------------------
// Each object passes the classifier in turn: an accept state, five
// multiplier steps on one shared 32x32 multiplier, a 32-step bit-serial
// remainder and a handoff state; when the modulus is zero the remainder is
// skipped and the key is the low half of the sum. The table engine makes
// sequential scans of the 64-slot key/object memory over its single read
// port (one for the match, a second for the oldest stamp only when the
// table is at its limit and an eviction is needed). The two halves run
// concurrently through a two-entry queue, and the table engine sets the
// sustained rate. A match is published through a result register while
// the next object is already being worked on; a held result stalls the
// engine only when the next match is ready to publish. There is no
// clearing pass after reset.
`default_nettype none
module hashed_object_pairing_table_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // tdata: coord_x[15:0], coord_y[31:16], coord_z[47:32], obj_class[55:48],
    // stamp[87:56]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,
    // tdata: key[15:0], out_x[31:16], out_y[47:32], out_z[63:48],
    // out_class[71:64], out_stamp[103:72]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [103:0]     m_tdata,
    // apb register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [6:0]         max_entries_reg;
    logic [15:0]        hash_base_reg;
    logic [15:0]        hash_modulus_reg;
    logic               cfg_wr;
    logic [1:0]         reg_idx;
    hopt_pkg::obj_t     in_obj;
    logic               fq_valid, fq_ready, qb_valid, qb_ready;
    hopt_pkg::item_t    fq_item, qb_item;
    hopt_pkg::result_t  res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= 7'd64;
            hash_base_reg <= 16'd31;
            hash_modulus_reg <= 16'd4093;
        end
        else if (cfg_wr)
        begin
            if (reg_idx == hopt_pkg::RegMaxEntries)
                max_entries_reg <= pwdata[6:0];
            else if (reg_idx == hopt_pkg::RegHashBase)
                hash_base_reg <= pwdata[15:0];
            else if (reg_idx == hopt_pkg::RegHashModulus)
                hash_modulus_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == hopt_pkg::RegMaxEntries)
            prdata = 32'(max_entries_reg);
        else if (reg_idx == hopt_pkg::RegHashBase)
            prdata = 32'(hash_base_reg);
        else if (reg_idx == hopt_pkg::RegHashModulus)
            prdata = 32'(hash_modulus_reg);
    end

    assign in_obj.x = s_tdata[15:0];
    assign in_obj.y = s_tdata[31:16];
    assign in_obj.z = s_tdata[47:32];
    assign in_obj.cls = s_tdata[55:48];
    assign in_obj.stamp = s_tdata[87:56];

    // front: hash key
    hopt_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_obj       (in_obj),
        .hash_base    (hash_base_reg),
        .hash_modulus (hash_modulus_reg),
        .out_valid    (fq_valid),
        .out_ready    (fq_ready),
        .out_item     (fq_item)
    );

    hopt_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_item  (fq_item),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_item  (qb_item)
    );

    // back: table match, eviction and store
    hopt_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (qb_valid),
        .in_ready    (qb_ready),
        .in_item     (qb_item),
        .max_entries (max_entries_reg),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res)
    );

    assign m_tdata = {res.obj.stamp, res.obj.cls, res.obj.z, res.obj.y, res.obj.x, res.key};
endmodule
`default_nettype wire

// ----- src/hopt_front.sv -----
// ----------------------------------------------------------------------------
// hopt_front
// accepts objects, computes the hash key with a shared multiplier and a
// restoring divider, and hands keyed items to the queue
// ----------------------------------------------------------------------------
`default_nettype none
module hopt_front
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire hopt_pkg::obj_t        in_obj,
    input  wire logic [15:0]           hash_base,
    input  wire logic [15:0]           hash_modulus,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output hopt_pkg::item_t            out_item
);
    localparam logic [3:0] StIdle = 4'd0;
    localparam logic [3:0] StA2   = 4'd1;
    localparam logic [3:0] StA3   = 4'd2;
    localparam logic [3:0] StMx   = 4'd3;
    localparam logic [3:0] StMy   = 4'd4;
    localparam logic [3:0] StMz   = 4'd5;
    localparam logic [3:0] StDiv  = 4'd6;
    localparam logic [3:0] StOut  = 4'd7;

    logic [3:0]      state_reg, state_next;
    hopt_pkg::obj_t  obj_reg, obj_next;
    logic [31:0]     a2_reg, a2_next, a3_reg, a3_next;
    logic [31:0]     sum_reg, sum_next;
    logic [31:0]     rem_reg, rem_next;
    logic [4:0]      bit_reg, bit_next;
    logic [15:0]     key_reg, key_next;
    logic [31:0]     mul_a, mul_b, mul_p;
    logic [32:0]     trial;

    assign mul_p = 32'(64'(mul_a) * 64'(mul_b));
    assign trial = {rem_reg, sum_reg[bit_reg]} - 33'(hash_modulus);

    always_comb
    begin
        mul_a = 32'(hash_base);
        mul_b = 32'(hash_base);
        unique case (state_reg)
            StA3:    begin mul_a = a2_reg; mul_b = 32'(hash_base); end
            StMx:    begin mul_a = 32'(obj_reg.x); mul_b = a3_reg; end
            StMy:    begin mul_a = 32'(obj_reg.y); mul_b = a2_reg; end
            StMz:    begin mul_a = 32'(obj_reg.z); mul_b = 32'(hash_base); end
            default: begin mul_a = 32'(hash_base); mul_b = 32'(hash_base); end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        obj_next = obj_reg;
        a2_next = a2_reg;
        a3_next = a3_reg;
        sum_next = sum_reg;
        rem_next = rem_reg;
        bit_next = bit_reg;
        key_next = key_reg;
        unique case (state_reg)
            StIdle:
            begin
                if (in_valid)
                begin
                    obj_next = in_obj;
                    state_next = StA2;
                end
            end
            StA2:
            begin
                a2_next = mul_p;
                state_next = StA3;
            end
            StA3:
            begin
                a3_next = mul_p;
                sum_next = 32'(obj_reg.cls);
                state_next = StMx;
            end
            StMx:
            begin
                sum_next = sum_reg + mul_p;
                state_next = StMy;
            end
            StMy:
            begin
                sum_next = sum_reg + mul_p;
                state_next = StMz;
            end
            StMz:
            begin
                sum_next = sum_reg + mul_p;
                rem_next = '0;
                bit_next = 5'd31;
                state_next = StDiv;
            end
            StDiv:
            begin
                // one quotient bit a cycle, remainder kept below the modulus
                if (hash_modulus == 16'd0)
                begin
                    key_next = sum_reg[15:0];
                    state_next = StOut;
                end
                else
                begin
                    if (!trial[32])
                        rem_next = trial[31:0];
                    else
                        rem_next = {rem_reg[30:0], sum_reg[bit_reg]};
                    if (bit_reg == 5'd0)
                    begin
                        key_next = !trial[32] ? trial[15:0]
                                              : {rem_reg[14:0], sum_reg[0]};
                        state_next = StOut;
                    end
                    else
                        bit_next = bit_reg - 5'd1;
                end
            end
            StOut:
            begin
                if (out_ready)
                    state_next = StIdle;
            end
            default: state_next = StIdle;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= StIdle;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        obj_reg <= obj_next;
        a2_reg <= a2_next;
        a3_reg <= a3_next;
        sum_reg <= sum_next;
        rem_reg <= rem_next;
        bit_reg <= bit_next;
        key_reg <= key_next;
    end

    assign in_ready = (state_reg == StIdle);
    assign out_valid = (state_reg == StOut);
    assign out_item.key = key_reg;
    assign out_item.obj = obj_reg;
endmodule
`default_nettype wire

// ----- src/hopt_queue.sv -----
// ----------------------------------------------------------------------------
// hopt_queue
// short fifo of keyed items between classifier and table engine
// ----------------------------------------------------------------------------
`default_nettype none
module hopt_queue
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire hopt_pkg::item_t  wr_item,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output hopt_pkg::item_t       rd_item
);
    localparam int PtrW = $clog2(hopt_pkg::QDepth);

    hopt_pkg::item_t   mem [hopt_pkg::QDepth];
    logic [PtrW-1:0]   wp_reg, rp_reg;
    logic [PtrW:0]     cnt_reg;
    logic              do_wr, do_rd;

    assign wr_ready = (cnt_reg != (PtrW+1)'(hopt_pkg::QDepth));
    assign rd_valid = (cnt_reg != '0);
    assign do_wr = wr_valid && wr_ready;
    assign do_rd = rd_valid && rd_ready;
    assign rd_item = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wp_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= (wp_reg == PtrW'(hopt_pkg::QDepth - 1)) ? '0 : wp_reg + 1'b1;
            if (do_rd)
                rp_reg <= (rp_reg == PtrW'(hopt_pkg::QDepth - 1)) ? '0 : rp_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end
endmodule
`default_nettype wire

// ----- src/hopt_back.sv -----
// ----------------------------------------------------------------------------
// hopt_back
// table engine: scans slots for match and oldest, picks the lowest free slot
// ----------------------------------------------------------------------------
`default_nettype none
module hopt_back
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire hopt_pkg::item_t       in_item,
    input  wire logic [6:0]            max_entries,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output hopt_pkg::result_t          res
);
    localparam int IdxW = hopt_pkg::IdxW;
    localparam int CntW = hopt_pkg::CntW;
    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StMatch = 3'd1;
    localparam logic [2:0] StHit   = 3'd2;
    localparam logic [2:0] StOld   = 3'd3;
    localparam logic [2:0] StStore = 3'd4;
    localparam logic [2:0] StWait  = 3'd5;

    // key and object memories, one read port, one write port
    logic [15:0]      key_mem [hopt_pkg::Capacity];
    hopt_pkg::obj_t   obj_mem [hopt_pkg::Capacity];
    logic [hopt_pkg::Capacity-1:0] valid_reg;

    logic [2:0]       state_reg;
    logic [CntW-1:0]  count_reg;
    logic [IdxW:0]    scan_reg;
    logic             rd_live_reg;
    logic [IdxW-1:0]  rd_idx_reg;
    logic [15:0]      rd_key_reg;
    hopt_pkg::obj_t   rd_obj_reg;
    hopt_pkg::item_t  item_reg;
    logic             best_ok_reg;
    logic [IdxW-1:0]  best_reg;
    logic [31:0]      best_stamp_reg;
    logic             hit_reg;
    logic [IdxW-1:0]  hit_idx_reg;
    hopt_pkg::obj_t   hit_obj_reg;
    logic             res_valid_reg;
    hopt_pkg::result_t res_reg;
    logic [CntW-1:0]  limit;
    logic [IdxW-1:0]  free_idx;
    logic             rd_hit;
    logic             scan_end;
    logic             res_set;

    always_comb
    begin
        if (max_entries == 7'd0)
            limit = CntW'(1);
        else if (32'(max_entries) > hopt_pkg::Capacity)
            limit = CntW'(hopt_pkg::Capacity);
        else
            limit = CntW'(max_entries);
    end

    // lowest free slot, priority pick over the valid bits
    always_comb
    begin
        free_idx = '0;
        for (int i = hopt_pkg::Capacity - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
                free_idx = IdxW'(i);
        end
    end

    assign rd_hit = rd_live_reg && valid_reg[rd_idx_reg] && (rd_key_reg == item_reg.key);
    assign scan_end = scan_reg[IdxW];
    // pending match moves into the result register once it is free
    assign res_set = (state_reg == StHit) && hit_reg && (!res_valid_reg || res_ready);

    always_ff @(posedge clk)
    begin
        rd_key_reg <= key_mem[scan_reg[IdxW-1:0]];
        rd_obj_reg <= obj_mem[scan_reg[IdxW-1:0]];
        rd_idx_reg <= scan_reg[IdxW-1:0];
        if (state_reg == StIdle && in_valid)
            item_reg <= in_item;
        if (state_reg == StStore)
        begin
            key_mem[free_idx] <= item_reg.key;
            obj_mem[free_idx] <= item_reg.obj;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StIdle;
            valid_reg <= '0;
            count_reg <= '0;
            scan_reg <= '0;
            rd_live_reg <= 1'b0;
            best_ok_reg <= 1'b0;
            best_reg <= '0;
            best_stamp_reg <= '0;
            hit_reg <= 1'b0;
            hit_idx_reg <= '0;
            hit_obj_reg <= '0;
            res_valid_reg <= 1'b0;
            res_reg <= '0;
        end
        else
        begin
            if (res_set)
                res_valid_reg <= 1'b1;
            else if (res_valid_reg && res_ready)
                res_valid_reg <= 1'b0;
            unique case (state_reg)
                StIdle:
                begin
                    if (in_valid)
                    begin
                        scan_reg <= '0;
                        rd_live_reg <= 1'b0;
                        hit_reg <= 1'b0;
                        state_reg <= StMatch;
                    end
                end
                StMatch:
                begin
                    // address issued in the cycle before its compare
                    if (!scan_end)
                        scan_reg <= scan_reg + 1'b1;
                    rd_live_reg <= !scan_end;
                    if (rd_hit && !hit_reg)
                    begin
                        hit_reg <= 1'b1;
                        hit_idx_reg <= rd_idx_reg;
                        hit_obj_reg <= rd_obj_reg;
                    end
                    if (scan_end && !rd_live_reg)
                        state_reg <= StHit;
                end
                StHit:
                begin
                    if (hit_reg)
                    begin
                        if (res_set)
                        begin
                            res_reg.key <= item_reg.key;
                            res_reg.obj <= hit_obj_reg;
                            valid_reg[hit_idx_reg] <= 1'b0;
                            count_reg <= count_reg - 1'b1;
                            hit_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        scan_reg <= '0;
                        rd_live_reg <= 1'b0;
                        best_ok_reg <= 1'b0;
                        state_reg <= (count_reg >= limit) ? StOld : StStore;
                    end
                end
                StOld:
                begin
                    if (!scan_end)
                        scan_reg <= scan_reg + 1'b1;
                    rd_live_reg <= !scan_end;
                    if (rd_live_reg && valid_reg[rd_idx_reg]
                        && (!best_ok_reg || rd_obj_reg.stamp < best_stamp_reg))
                    begin
                        best_ok_reg <= 1'b1;
                        best_reg <= rd_idx_reg;
                        best_stamp_reg <= rd_obj_reg.stamp;
                    end
                    if (scan_end && !rd_live_reg)
                    begin
                        if (best_ok_reg)
                        begin
                            valid_reg[best_reg] <= 1'b0;
                            count_reg <= count_reg - 1'b1;
                        end
                        state_reg <= StWait;
                    end
                end
                StWait:
                    state_reg <= StStore;
                StStore:
                begin
                    if (!(&valid_reg))
                    begin
                        valid_reg[free_idx] <= 1'b1;
                        count_reg <= count_reg + 1'b1;
                    end
                    state_reg <= StIdle;
                end
                default: state_reg <= StIdle;
            endcase
        end
    end

    assign in_ready = (state_reg == StIdle);
    assign res_valid = res_valid_reg;
    assign res = res_reg;
endmodule
`default_nettype wire

// ----- src/hopt_checker.sv -----
// ----------------------------------------------------------------------------
// hopt_checker
// port-level checks of the pairing table
// ----------------------------------------------------------------------------
`default_nettype none
`include "hashed_object_pairing_table_core_defines.svh"
module hopt_checker
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [103:0] m_tdata,
    input wire logic         pready
);
    `HOPT_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped while stalled")
    `HOPT_ASSERT_IMP(a_pready, clk, rst_n, 1'b1, pready, "pready low")
    `HOPT_ASSERT_NEXT(a_in_gap, clk, rst_n, s_tvalid && s_tready, !s_tready, "input taken twice in a row")
endmodule

bind hashed_object_pairing_table_core hopt_checker u_hopt_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
`default_nettype wire
